@@ sv/flsa_pkg.sv @@
// Package for the free-list slot allocator: payload structs, request and
// status codes, controller states and the controller/datapath interface.
// Depends on nothing.
package flsa_pkg;

	localparam int NUM_SLOTS_DEF = 64;
	localparam int SLOT_W        = 6;
	localparam int CNT_W         = 7;
	localparam int SLOT_FIELD_MAX = 64;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	localparam logic [1:0] REQ_ACQUIRE = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_RESET   = 2'd2;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_EMPTY   = 2'd1;
	localparam logic [1:0] STS_REFUSED = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic [1:0]        status;
		logic [CNT_W-1:0]  free_count;
		logic [CNT_W-1:0]  used_count;
	} rsp_t;

	typedef enum logic [1:0] {
		FSM_INIT,
		FSM_IDLE,
		FSM_EXEC,
		FSM_RELINK
	} fsm_state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic relink;
		logic report;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_reset;
		logic relink_last;
	} dp_status_t;

endpackage

@@ sv/flsa_ctrl.sv @@
// Controller state machine of the free-list slot allocator.
// Sequences request execution and the relink pass; uses flsa_pkg.
module flsa_ctrl
	import flsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	fsm_state_t state_q;
	fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_INIT: begin
				if (sts.relink_last) state_d = FSM_IDLE;
			end
			FSM_IDLE: begin
				if (start) state_d = FSM_EXEC;
			end
			FSM_EXEC: begin
				state_d = sts.req_reset ? FSM_RELINK : FSM_IDLE;
			end
			FSM_RELINK: begin
				if (sts.relink_last) state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		case (state_q)
			FSM_INIT: begin
				cmd.relink = 1'b1;
			end
			FSM_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			FSM_EXEC: begin
				cmd.exec = 1'b1;
			end
			FSM_RELINK: begin
				cmd.relink = 1'b1;
				cmd.report = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

@@ sv/flsa_dp.sv @@
// Datapath of the free-list slot allocator: link memory, list head, counts,
// capacity register, relink counter and result register; uses flsa_pkg.
module flsa_dp
	import flsa_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output dp_status_t       sts,
	output logic             done,
	output rsp_t             rsp
);

	localparam int AW      = $clog2(NUM_SLOTS);
	localparam int LW      = $clog2(NUM_SLOTS + 1);
	localparam int CW      = (LW > CNT_W) ? LW : CNT_W;
	localparam int CAP_LIM = (NUM_SLOTS > SLOT_FIELD_MAX) ? SLOT_FIELD_MAX : NUM_SLOTS;

	localparam logic [CNT_W-1:0] CAP_LIM_V = CNT_W'(CAP_LIM);
	localparam logic [LW-1:0]    NULL_LINK = LW'(NUM_SLOTS);

	logic [LW-1:0] link_mem [NUM_SLOTS];

	logic [CNT_W-1:0]  cap_reg_q;
	logic [CNT_W-1:0]  cap;
	req_t              req_q;
	logic [LW-1:0]     head_q;
	logic [LW-1:0]     rd_q;
	logic [CNT_W-1:0]  free_q;
	logic [CNT_W-1:0]  used_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              acq_ok;
	logic              rel_ok;
	logic              relink_last;
	logic [CNT_W-1:0]  cnt_next;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [LW-1:0]     mem_wdata;
	logic              load_state;
	logic [LW-1:0]     head_d;
	logic [CNT_W-1:0]  free_d;
	logic [CNT_W-1:0]  used_d;
	logic              emit;
	rsp_t              rsp_d;

	always_comb begin
		if (cap_reg_q == '0) begin
			cap = CNT_W'(1);
		end else if (cap_reg_q > CAP_LIM_V) begin
			cap = CAP_LIM_V;
		end else begin
			cap = cap_reg_q;
		end
	end

	assign cnt_next    = {1'b0, cnt_q} + CNT_W'(1);
	assign relink_last = cnt_next == cap;
	assign acq_ok      = (free_q != '0) && (CW'(head_q) < CW'(cap));
	assign rel_ok      = (used_q != '0) && ({1'b0, req_q.slot_index} < cap);

	assign sts.req_reset   = req_q.req_type == REQ_RESET;
	assign sts.relink_last = relink_last;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(req_q.slot_index);
		mem_wdata = head_q;
		if (cmd.relink) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(cnt_q);
			mem_wdata = relink_last ? NULL_LINK : LW'(cnt_next);
		end else if (cmd.exec && req_q.req_type == REQ_RELEASE && rel_ok) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		load_state = 1'b0;
		head_d     = head_q;
		free_d     = free_q;
		used_d     = used_q;
		emit       = 1'b0;
		rsp_d      = '0;
		rsp_d.status = STS_OK;
		if (cmd.relink) begin
			if (relink_last) begin
				load_state = 1'b1;
				head_d     = '0;
				free_d     = cap;
				used_d     = '0;
				emit       = cmd.report;
			end
		end else if (cmd.exec) begin
			emit = req_q.req_type != REQ_RESET;
			case (req_q.req_type)
				REQ_ACQUIRE: begin
					if (acq_ok) begin
						load_state         = 1'b1;
						head_d             = rd_q;
						free_d             = free_q - CNT_W'(1);
						used_d             = used_q + CNT_W'(1);
						rsp_d.granted_slot = SLOT_W'(head_q);
					end else begin
						rsp_d.status = STS_EMPTY;
					end
				end
				REQ_RELEASE: begin
					if (rel_ok) begin
						load_state = 1'b1;
						head_d     = LW'(req_q.slot_index);
						free_d     = free_q + CNT_W'(1);
						used_d     = used_q - CNT_W'(1);
					end else begin
						rsp_d.status = STS_REFUSED;
					end
				end
				default: begin
					rsp_d.status = STS_OK;
				end
			endcase
		end
		rsp_d.free_count = free_d;
		rsp_d.used_count = used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg_q <= CAP_RESET;
			head_q    <= '0;
			free_q    <= '0;
			used_q    <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) cap_reg_q <= cfg_wdata;
			if (load_state) begin
				head_q <= head_d;
				free_q <= free_d;
				used_q <= used_d;
			end
			if (cmd.relink) cnt_q <= relink_last ? '0 : SLOT_W'(cnt_next);
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= req;
		if (emit) rsp_q <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) link_mem[mem_waddr] <= mem_wdata;
		rd_q <= link_mem[AW'(head_q)];
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ sv/free_list_slot_allocator.sv @@
// Top level of the LIFO free-list slot allocator.
// Instantiates flsa_ctrl and flsa_dp; uses flsa_pkg.
//
// Channel   Signals                Beat taken at
// request   start, req, busy       rising edge with start high and busy low
// result    done, rsp              rising edge ending the cycle done is high
// config    cfg_we, cfg_wdata      rising edge with cfg_we high
//
// An acquire or release executes in the cycle after its accepting edge and its
// result beat is on the ports in the cycle after that, with busy already low;
// no new request is taken during EXEC, which the registered link read requires.
// A pool reset keeps busy high through its EXEC and RELINK states while
// the link memory is rewritten one entry a cycle; its result follows.
// After reset the same relink pass runs with no result beat; the receiver cannot stall.
module free_list_slot_allocator
	import flsa_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	output logic             busy,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	flsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	flsa_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the free-list slot allocator: directed and random
// acquire, release and pool reset beats, checked against a scoreboard predictor.
// Depends on flsa_pkg and free_list_slot_allocator.
module tb_top;
	import flsa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	class slot_pool_scoreboard;
		logic [CNT_W-1:0] cap_reg;
		logic [CNT_W-1:0] link [NUM_SLOTS_DEF];
		logic [CNT_W-1:0] head;
		logic [CNT_W-1:0] n_free;
		logic [CNT_W-1:0] n_used;
		bit               held [NUM_SLOTS_DEF];
		rsp_t             expected_rsp [$];
		int               errors;

		function new();
			cap_reg = CAP_RESET;
			errors = 0;
			relink();
		endfunction

		function int eff_cap();
			int c;
			c = int'(cap_reg);
			if (c < 1) c = 1;
			if (c > NUM_SLOTS_DEF) c = NUM_SLOTS_DEF;
			return c;
		endfunction

		function void relink();
			int cap;
			cap = eff_cap();
			for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
				link[i] = (i + 1 < cap) ? CNT_W'(i + 1) : CNT_W'(NUM_SLOTS_DEF);
				held[i] = 1'b0;
			end
			head = '0;
			n_free = CNT_W'(cap);
			n_used = '0;
		endfunction

		function void set_capacity(logic [CNT_W-1:0] value);
			cap_reg = value;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		function int pick_held();
			int cands [$];
			foreach (held[i]) if (held[i]) cands.push_back(i);
			if (cands.size() == 0) return -1;
			return cands[$urandom_range(cands.size() - 1)];
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int cap;
			cap = eff_cap();
			e = '0;
			case (r.req_type)
				REQ_ACQUIRE: begin
					if (n_free == 0 || head >= cap) begin
						e.status = STS_EMPTY;
					end else begin
						e.granted_slot = head[SLOT_W-1:0];
						held[head] = 1'b1;
						head = link[head];
						n_free = n_free - 1'b1;
						n_used = n_used + 1'b1;
					end
				end
				REQ_RELEASE: begin
					if (n_used == 0 || r.slot_index >= cap) begin
						e.status = STS_REFUSED;
					end else begin
						link[r.slot_index] = head;
						head = CNT_W'(r.slot_index);
						held[r.slot_index] = 1'b0;
						n_free = n_free + 1'b1;
						n_used = n_used - 1'b1;
					end
				end
				REQ_RESET: relink();
				default: ;
			endcase
			e.free_count = n_free;
			e.used_count = n_used;
			expected_rsp.push_back(e);
		endfunction

		function void compare_field(string name, logic [7:0] expv, logic [7:0] act);
			if (act !== expv) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, expv, act);
			end
		endfunction

		function void check_response(rsp_t a);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, expected none, got %h",
					$time, a);
				return;
			end
			e = expected_rsp.pop_front();
			compare_field("granted_slot", 8'(e.granted_slot), 8'(a.granted_slot));
			compare_field("status", 8'(e.status), 8'(a.status));
			compare_field("free_count", 8'(e.free_count), 8'(a.free_count));
			compare_field("used_count", 8'(e.used_count), 8'(a.used_count));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	req_t             req = '0;
	logic             busy;
	logic             done;
	rsp_t             rsp;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	bit               gaps_on = 1'b1;

	slot_pool_scoreboard sb = new();

	free_list_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_response(rsp);
	end

	task automatic wait_idle();
		@(negedge clk);
		while (sb.pending() != 0 || busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic issue(input logic [1:0] op, input logic [SLOT_W-1:0] slot);
		req_t r;
		r.req_type = op;
		r.slot_index = slot;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		if (gaps_on && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] value);
		start <= 1'b0;
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(value);
	endtask

	task automatic random_item(input int acq_bias);
		int roll;
		int s;
		roll = $urandom_range(99);
		if (roll < 4) begin
			issue(REQ_RESET, SLOT_W'($urandom));
		end else if (roll < 16) begin
			issue(2'($urandom), SLOT_W'($urandom));
		end else begin
			s = sb.pick_held();
			if (s >= 0 && $urandom_range(99) >= acq_bias) issue(REQ_RELEASE, SLOT_W'(s));
			else issue(REQ_ACQUIRE, SLOT_W'($urandom));
		end
	endtask

	initial begin
		int ph;
		int bias;
		logic [CNT_W-1:0] v;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		wait_idle();

		issue(REQ_RELEASE, 6'd5);
		issue(2'd3, 6'd63);
		issue(REQ_ACQUIRE, 6'd63);
		issue(REQ_ACQUIRE, 6'd0);
		issue(REQ_RELEASE, 6'd1);
		issue(REQ_RELEASE, 6'd1);
		issue(REQ_ACQUIRE, 6'd0);
		issue(REQ_RELEASE, 6'd63);
		issue(REQ_RELEASE, 6'd0);
		write_capacity(7'd1);
		issue(REQ_ACQUIRE, 6'd0);
		issue(REQ_RELEASE, 6'd0);
		issue(REQ_RESET, 6'd63);
		issue(REQ_ACQUIRE, 6'd0);
		issue(REQ_ACQUIRE, 6'd0);
		issue(REQ_RELEASE, 6'd63);
		issue(REQ_RELEASE, 6'd0);
		write_capacity(7'd0);
		issue(REQ_RESET, 6'd0);
		issue(REQ_ACQUIRE, 6'd0);
		issue(REQ_RELEASE, 6'd0);
		write_capacity(7'd127);
		issue(REQ_RESET, 6'd0);
		issue(REQ_ACQUIRE, 6'd63);
		issue(REQ_RELEASE, 6'd63);
		issue(REQ_ACQUIRE, 6'd0);

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: v = 7'd64;
				1: v = 7'd1;
				2: v = 7'd2;
				3: v = 7'd127;
				4: v = 7'd0;
				5: v = 7'($urandom_range(65, 126));
				default: v = 7'($urandom_range(3, 63));
			endcase
			gaps_on = (ph != 6);
			write_capacity(v);
			if (ph != 5) issue(REQ_RESET, SLOT_W'($urandom));
			bias = $urandom_range(30, 85);
			repeat (150) random_item(bias);
		end

		start <= 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("free_list_slot_allocator verification clean");
		end else begin
			$display("free_list_slot_allocator verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("free_list_slot_allocator verification failed");
		$finish;
	end

endmodule
